// ===== sv/swpp_pkg.sv =====
// ============================================================================
// swpp_pkg
// shared types and constants of the sliding window peak-to-peak block
// ============================================================================
`default_nettype none

package swpp_pkg;

    localparam int DATA_W = 32;
    localparam int WLEN_W = 11;

    // status that a deque unit reports to the top level
    typedef struct packed {
        logic                     idle;
        logic signed [DATA_W-1:0] front;
    } dq_status_t;

endpackage

`default_nettype wire

// ===== sv/swpp_sample_if.sv =====
// ============================================================================
// swpp_sample_if
// sample channel: valid/ready with one signed sample and an end mark
// ============================================================================
`default_nettype none

interface swpp_sample_if;

    logic                             valid;
    logic                             ready;
    logic signed [swpp_pkg::DATA_W-1:0] sample;
    logic                             last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);

endinterface

`default_nettype wire

// ===== sv/swpp_result_if.sv =====
// ============================================================================
// swpp_result_if
// result channel: valid/ready with the largest spread and a found flag
// ============================================================================
`default_nettype none

interface swpp_result_if;

    logic                        valid;
    logic                        ready;
    logic [swpp_pkg::DATA_W-1:0] best_spread;
    logic                        found;

    modport source (output valid, output best_spread, output found, input ready);
    modport sink   (input valid, input best_spread, input found, output ready);

endinterface

`default_nettype wire

// ===== sv/swpp_deque.sv =====
// ============================================================================
// swpp_deque
// monotonic deque in a circular single-port-read memory: drops expired
// entries at the front, dominated entries at the back, then pushes the sample
// ============================================================================
`default_nettype none

module swpp_deque #(
    parameter int DEPTH = 1024,
    parameter int TAG_W = 11,
    parameter int CNT_W = 11
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 keep_max,
    input  wire logic                                 start,
    input  wire logic                                 clear,
    input  wire logic signed [swpp_pkg::DATA_W-1:0]   sample,
    input  wire logic        [TAG_W-1:0]              tag,
    input  wire logic        [CNT_W-1:0]              win,
    output swpp_pkg::dq_status_t                      status
);

    localparam int AW = $clog2(DEPTH);
    localparam int MW = TAG_W + swpp_pkg::DATA_W;

    typedef enum logic [1:0] {
        D_IDLE,
        D_FRONT,
        D_BACK
    } dq_state_t;

    dq_state_t                           state_reg, state_next;
    logic        [AW-1:0]                head_reg, head_next;
    logic        [CNT_W-1:0]             count_reg, count_next;
    logic signed [swpp_pkg::DATA_W-1:0]  front_reg, front_next;
    logic signed [swpp_pkg::DATA_W-1:0]  val_reg;
    logic        [TAG_W-1:0]             tag_reg;
    logic        [CNT_W-1:0]             win_reg;

    logic [MW-1:0]                       entry_mem [DEPTH];
    logic [MW-1:0]                       rd_data_reg;
    logic [AW-1:0]                       rd_addr;
    logic                                wr_en;
    logic [AW-1:0]                       wr_addr;
    logic [MW-1:0]                       wr_data;

    logic        [TAG_W-1:0]             rd_tag;
    logic signed [swpp_pkg::DATA_W-1:0]  rd_val;
    logic        [TAG_W-1:0]             age;
    logic                                expired;
    logic                                dominated;

    // circular slot: head plus offset, wrapped at the depth
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        begin
            s = (CNT_W+1)'(h) + {1'b0, k};
            if (s >= (CNT_W+1)'(DEPTH))
            begin
                s = s - (CNT_W+1)'(DEPTH);
            end
            return s[AW-1:0];
        end
    endfunction

    assign rd_tag    = rd_data_reg[MW-1:swpp_pkg::DATA_W];
    assign rd_val    = signed'(rd_data_reg[swpp_pkg::DATA_W-1:0]);
    assign age       = tag_reg - rd_tag;
    assign expired   = (age >= TAG_W'(win_reg));
    assign dominated = keep_max ? (rd_val <= val_reg) : (rd_val >= val_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        front_next = front_reg;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_addr    = head_reg;
        wr_data    = {tag_reg, val_reg};
        case (state_reg)
            D_IDLE:
            begin
                if (clear)
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                else if (start)
                begin
                    if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {tag, sample};
                        count_next = CNT_W'(1);
                        front_next = sample;
                    end
                    else
                    begin
                        state_next = D_FRONT;
                    end
                end
            end
            D_FRONT:
            begin
                if (expired)
                begin
                    head_next = slot(head_reg, CNT_W'(1));
                    if (count_reg == CNT_W'(1))
                    begin
                        // whole deque expired
                        wr_en      = 1'b1;
                        wr_addr    = slot(head_reg, CNT_W'(1));
                        front_next = val_reg;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        rd_addr    = slot(head_reg, CNT_W'(1));
                    end
                end
                else
                begin
                    front_next = rd_val;
                    rd_addr    = slot(head_reg, count_reg - CNT_W'(1));
                    state_next = D_BACK;
                end
            end
            D_BACK:
            begin
                if (dominated)
                begin
                    if (count_reg == CNT_W'(1))
                    begin
                        // new sample replaces the front entry
                        wr_en      = 1'b1;
                        front_next = val_reg;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        rd_addr    = slot(head_reg, count_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = slot(head_reg, count_reg);
                    count_next = count_reg + CNT_W'(1);
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        if (start && (state_reg == D_IDLE))
        begin
            val_reg <= sample;
            tag_reg <= tag;
            win_reg <= win;
        end
    end

    assign status.idle  = (state_reg == D_IDLE);
    assign status.front = front_reg;

endmodule

`default_nettype wire

// ===== sv/sliding_window_peak_to_peak_max_top.sv =====
// ============================================================================
// sliding_window_peak_to_peak_max_top
// largest max-minus-min over every full window of a sample sequence,
// reported once per sequence on the sample marked last
// ============================================================================
//
//  channel    role    handshake    payload
//  samples    sink    valid/ready  sample (s32), last
//  results    source  valid/ready  best_spread (u32), found
//  cfg        write   cfg_wr_en    cfg_wr_data = window_length (u11)
//
//  the time from one sample transfer to the next grows with the expired front
//  entries and the dominated back entries that the slower deque has to pop
//  each deque memory reads one entry per cycle, which sets the pop rate
//  no clearing pass: deque entries are only read below their fill count
//  a result waiting in the output register does not block the next sample;
//  only a new last sample stalls until that result has been taken
//
`default_nettype none

module sliding_window_peak_to_peak_max_top #(
    parameter int MAX_WINDOW = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    swpp_sample_if.sink                      samples,
    swpp_result_if.source                    results,
    input  wire logic                        cfg_wr_en,
    input  wire logic [swpp_pkg::WLEN_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int TAG_W = $clog2(MAX_WINDOW) + 1;
    localparam int CMP_W = (CNT_W > swpp_pkg::WLEN_W) ? CNT_W : swpp_pkg::WLEN_W;

    typedef enum logic {
        S_IDLE,
        S_WAIT
    } state_t;

    state_t                          state_reg;
    logic [swpp_pkg::WLEN_W-1:0]     window_length_reg;
    logic [CNT_W-1:0]                w_reg;
    logic [CNT_W-1:0]                pos_reg;
    logic [TAG_W-1:0]                serial_reg;
    logic                            last_reg;
    logic [swpp_pkg::DATA_W-1:0]     best_reg;
    logic                            any_reg;
    logic                            out_valid_reg;
    logic [swpp_pkg::DATA_W-1:0]     out_best_reg;
    logic                            out_found_reg;

    logic [CMP_W-1:0]                wl_ext;
    logic [CNT_W-1:0]                w_eff;
    logic                            accept;
    logic                            both_idle;
    logic                            out_blocked;
    logic                            finish;
    logic                            window_full;
    logic [swpp_pkg::DATA_W-1:0]     spread;
    logic [swpp_pkg::DATA_W-1:0]     best_next;
    logic                            any_next;
    logic                            seq_clear;

    swpp_pkg::dq_status_t            max_st;
    swpp_pkg::dq_status_t            min_st;

    // effective window: zero means one, clamp to the deque depth
    assign wl_ext = CMP_W'(window_length_reg);

    always_comb
    begin
        if (wl_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (wl_ext > CMP_W'(MAX_WINDOW))
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = wl_ext[CNT_W-1:0];
        end
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign both_idle     = max_st.idle && min_st.idle;
    assign out_blocked   = last_reg && out_valid_reg && !results.ready;
    assign finish        = (state_reg == S_WAIT) && both_idle && !out_blocked;
    assign seq_clear     = finish && last_reg;

    assign window_full = (pos_reg >= w_reg);
    assign spread      = unsigned'(max_st.front) - unsigned'(min_st.front);
    assign best_next   = (window_full && (!any_reg || (spread > best_reg))) ? spread : best_reg;
    assign any_next    = any_reg || window_full;

    swpp_deque #(
        .DEPTH (MAX_WINDOW),
        .TAG_W (TAG_W),
        .CNT_W (CNT_W)
    ) u_max_dq (
        .clk      (clk),
        .rst_n    (rst_n),
        .keep_max (1'b1),
        .start    (accept),
        .clear    (seq_clear),
        .sample   (samples.sample),
        .tag      (serial_reg),
        .win      (w_eff),
        .status   (max_st)
    );

    swpp_deque #(
        .DEPTH (MAX_WINDOW),
        .TAG_W (TAG_W),
        .CNT_W (CNT_W)
    ) u_min_dq (
        .clk      (clk),
        .rst_n    (rst_n),
        .keep_max (1'b0),
        .start    (accept),
        .clear    (seq_clear),
        .sample   (samples.sample),
        .tag      (serial_reg),
        .win      (w_eff),
        .status   (min_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            window_length_reg <= swpp_pkg::WLEN_W'(1);
            w_reg             <= CNT_W'(1);
            pos_reg           <= '0;
            serial_reg        <= '0;
            last_reg          <= 1'b0;
            best_reg          <= '0;
            any_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            out_best_reg      <= '0;
            out_found_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                window_length_reg <= cfg_wr_data;
            end
            if (seq_clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg   <= samples.last;
                        w_reg      <= w_eff;
                        serial_reg <= serial_reg + TAG_W'(1);
                        if (pos_reg < CNT_W'(MAX_WINDOW))
                        begin
                            pos_reg <= pos_reg + CNT_W'(1);
                        end
                        state_reg  <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                        if (last_reg)
                        begin
                            out_best_reg  <= best_next;
                            out_found_reg <= any_next;
                            best_reg      <= '0;
                            any_reg       <= 1'b0;
                            pos_reg       <= '0;
                            serial_reg    <= '0;
                        end
                        else
                        begin
                            best_reg <= best_next;
                            any_reg  <= any_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.best_spread = out_best_reg;
    assign results.found       = out_found_reg;

`ifndef SYNTHESIS
    // no window means nothing to report
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.found |-> results.best_spread == '0)
        else $error("spread reported without a full window");

    // one sample in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("sample taken while a sample is in flight");

    // a finished last sample always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_clear |=> results.valid && (state_reg == S_IDLE))
        else $error("sequence end did not produce a result");

    // both deques start on the same sample and are idle whenever the block is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> both_idle)
        else $error("deque busy while the block is idle");
`endif

endmodule

`default_nettype wire
